// ===== hdl/fdtf_pkg.sv =====
`timescale 1ns / 1ps
package fdtf_pkg;

   localparam int CHAR_BITS = 8;
   localparam int DEC_BITS  = 4;
   localparam int BCD_BITS  = 4;

   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_BITS-1:0] CH_POINT = 8'h2e;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CONV  = 6'b000010,
      ST_SIGN  = 6'b000100,
      ST_INT   = 6'b001000,
      ST_POINT = 6'b010000,
      ST_FRAC  = 6'b100000
   } fdtf_state_type;

endpackage

// ===== hdl/fdtf_req_if.sv =====
`timescale 1ns / 1ps
interface fdtf_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                            valid;
   logic                            ready;
   logic signed [VALUE_BITS-1:0]    value;
   logic [fdtf_pkg::DEC_BITS-1:0]   decimals;

   modport source (output valid, output value, output decimals, input ready);
   modport sink   (input valid, input value, input decimals, output ready);
endinterface

// ===== hdl/fdtf_rsp_if.sv =====
`timescale 1ns / 1ps
interface fdtf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fdtf_pkg::CHAR_BITS-1:0]  text_char;
   logic                            last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== hdl/fdtf_bcd_conv.sv =====
`timescale 1ns / 1ps
module fdtf_bcd_conv #(
   parameter int VALUE_BITS = 32,
   parameter int DIGITS     = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [VALUE_BITS-1:0]                  mag,
   output logic                                   done,
   output logic [DIGITS*fdtf_pkg::BCD_BITS-1:0]   bcd
);
   import fdtf_pkg::*;

   localparam int BW = DIGITS * BCD_BITS;
   localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [BW-1:0]         bcd_ff, bcd_in;
   logic [BW-1:0]         adj;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*BCD_BITS +: BCD_BITS] >= BCD_BITS'(5)) begin
            adj[i*BCD_BITS +: BCD_BITS] = bcd_ff[i*BCD_BITS +: BCD_BITS] + BCD_BITS'(3);
         end else begin
            adj[i*BCD_BITS +: BCD_BITS] = bcd_ff[i*BCD_BITS +: BCD_BITS];
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = mag;
         bcd_in   = '0;
         cnt_in   = CW'(VALUE_BITS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = {adj[BW-2:0], shift_ff[VALUE_BITS-1]};
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// ===== hdl/fixed_decimal_text_formatter_core.sv =====
`timescale 1ns / 1ps
// Prints a signed scaled integer as fixed-point decimal ASCII text, one character per
// response, with last_char set on the final one: an optional '-', the integer part
// without leading zeros ('0' when it is zero), and, when the fraction is nonzero, a '.'
// and the fraction with its trailing zeros dropped. decimals above MAX_DECIMALS count as
// MAX_DECIMALS. A request is taken only while the core is idle; it then loads the
// bit-serial binary-to-BCD converter, runs it over every bit of the value, hands the
// digits over, skips each leading zero digit above the integer part, and then emits
// the characters, waiting whenever the sink stalls. The last character may still
// wait in the output register while the next request is accepted.
module fixed_decimal_text_formatter_core #(
   parameter int VALUE_BITS   = 32,
   parameter int MAX_DECIMALS = 9
) (
   input  logic          clock,
   input  logic          reset,
   fdtf_req_if.sink      req_ch,
   fdtf_rsp_if.source    rsp_ch
);
   import fdtf_pkg::*;

   localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int W    = (NDIG > MAX_DECIMALS + 1) ? NDIG : MAX_DECIMALS + 1;
   localparam int BW   = W * BCD_BITS;
   localparam int PW   = $clog2(W);

   fdtf_state_type         state_ff, state_in;
   logic [BW-1:0]          dig_ff, dig_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [PW-1:0]          d_ff, d_in;
   logic                   neg_ff, neg_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]   text_char_ff, text_char_in;
   logic                   last_char_ff, last_char_in;

   logic                   req_fire;
   logic                   out_free;
   logic [BCD_BITS-1:0]    digit;
   logic [CHAR_BITS-1:0]   digit_char;
   logic                   rest_zero;
   logic [VALUE_BITS-1:0]  mag;
   logic                   conv_done;
   logic [BW-1:0]          conv_bcd;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign digit      = dig_ff[BW-1 -: BCD_BITS];
   assign digit_char = CH_ZERO + CHAR_BITS'(digit);
   assign rest_zero  = (dig_ff[BW-BCD_BITS-1:0] == '0);

   // the most negative value wraps onto its own unsigned magnitude
   assign mag = req_ch.value[VALUE_BITS-1] ? (~req_ch.value + VALUE_BITS'(1))
                                           : req_ch.value;

   fdtf_bcd_conv #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (W)
   ) u_conv (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .mag   (mag),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      pos_in       = pos_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      text_char_in = text_char_ff;
      last_char_in = last_char_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in = req_ch.value[VALUE_BITS-1];
               if (int'(req_ch.decimals) > MAX_DECIMALS) begin
                  d_in = PW'(MAX_DECIMALS);
               end else begin
                  d_in = PW'(req_ch.decimals);
               end
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               dig_in     = conv_bcd;
               pos_in     = PW'(W - 1);
               started_in = 1'b0;
               state_in   = neg_ff ? ST_SIGN : ST_INT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               text_char_in = CH_MINUS;
               last_char_in = 1'b0;
               state_in     = ST_INT;
            end
         end
         ST_INT: begin
            if (!started_ff && digit == '0 && pos_ff != d_ff) begin
               // drop a leading zero
               dig_in = dig_ff << BCD_BITS;
               pos_in = pos_ff - PW'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               text_char_in = digit_char;
               last_char_in = 1'b0;
               started_in   = 1'b1;
               dig_in       = dig_ff << BCD_BITS;
               pos_in       = pos_ff - PW'(1);
               if (pos_ff == d_ff) begin
                  if (rest_zero) begin
                     last_char_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_POINT;
                  end
               end
            end
         end
         ST_POINT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               text_char_in = CH_POINT;
               last_char_in = 1'b0;
               state_in     = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               text_char_in = digit_char;
               last_char_in = rest_zero;
               dig_in       = dig_ff << BCD_BITS;
               if (rest_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
      end
      dig_ff       <= dig_in;
      pos_ff       <= pos_in;
      d_ff         <= d_in;
      neg_ff       <= neg_in;
      text_char_ff <= text_char_in;
      last_char_ff <= last_char_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.text_char = text_char_ff;
   assign rsp_ch.last_char = last_char_ff;

`ifndef ASSERT_OFF
   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_CONV)
      else $error("accepted request did not start conversion");

   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> state_ff == ST_CONV)
      else $error("converter finished outside conversion phase");

   a_sign_only_negative: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> neg_ff)
      else $error("minus sign phase for a non-negative value");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && last_char_in && !(rsp_valid_ff && !rsp_ch.ready)) |=>
         state_ff == ST_IDLE)
      else $error("last character emitted without returning to idle");
`endif

endmodule
